### sv/skf_pkg.sv
// Package: shared types and constants of the scalar Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
package skf_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned MUL_A_W  = 34;
  localparam int unsigned MUL_B_W  = 18;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_STEPS = GAIN_W;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd33;
  localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd655360;
  localparam logic [GAIN_W-1:0] GAIN_MAX          = 16'hFFFF;
  localparam logic [GAIN_W:0]   ONE_Q16           = 17'h10000;

  // register index, taken from paddr[2]
  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASURE_NOISE = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] measurement;
    logic                     restart;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic [GAIN_W-1:0]        gain;
  } out_t;

endpackage
`default_nettype wire

### sv/scalar_kalman_filter_top.sv
// Top level: scalar Kalman filter with iterative gain divider and shared multiplier.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one measurement transaction
//   at a time; in_data.restart zeroes estimate and variance before the update.
//   Output channel (out_valid/out_ready/out_data) returns one transaction per
//   input: the new estimate (Q16.16) and the gain used (Q0.16).
//   APB port sets process noise (0x0) and measurement noise (0x4); write only
//   while the filter is idle. pready is tied high, reads return the register.
// Sequence:
//   After an input transaction the filter steps through prediction, the
//   restoring gain divider (one quotient bit per cycle), the estimate and
//   variance products of the shared multiplier, the variance update and a
//   finishing step that loads the result into the output register. in_ready
//   returns high as the result is loaded, so a new measurement is taken only
//   after the last one is through. The divider is skipped when measurement noise is zero.
// Reset and stalls:
//   rst_n (synchronous) clears estimate and variance and restores the default
//   noise values. If out_ready is low, the result waits in the output register
//   and the next input is still accepted; a second finished result waits in
//   the sequencer until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module scalar_kalman_filter_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire skf_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output skf_pkg::out_t                         out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [skf_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [skf_pkg::DATA_W-1:0]       pwdata,
  output logic [skf_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PRED    = 7'b0000010,
    S_DIV     = 7'b0000100,
    S_MUL_EST = 7'b0001000,
    S_MUL_VAR = 7'b0010000,
    S_VAR     = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [skf_pkg::DATA_W-1:0]        pn_r, pn_nxt;
  logic [skf_pkg::DATA_W-1:0]        mn_r, mn_nxt;
  logic signed [skf_pkg::DATA_W-1:0] z_r, z_nxt;
  logic signed [skf_pkg::DATA_W-1:0] ev_r, ev_nxt;
  logic [skf_pkg::DATA_W-1:0]        var_r, var_nxt;
  logic [skf_pkg::DATA_W-1:0]        p_r, p_nxt;
  logic [skf_pkg::DATA_W:0]          s_r, s_nxt;
  logic [skf_pkg::DATA_W+1:0]        rem_r, rem_nxt;
  logic [skf_pkg::GAIN_W-1:0]        q_r, q_nxt;
  logic [skf_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  skf_pkg::out_t                     out_r, out_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic                              cfg_wr;
  logic                              in_acc;
  logic [skf_pkg::DATA_W:0]          psum;
  logic [skf_pkg::DATA_W-1:0]        p_pred;
  logic [skf_pkg::DATA_W+1:0]        rem_sh;
  logic [skf_pkg::DATA_W+2:0]        rem_sub;
  logic signed [skf_pkg::DATA_W:0]   diff;
  logic signed [skf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [skf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [skf_pkg::MUL_P_W-1:0] prod_r;
  logic [skf_pkg::DATA_W-1:0]        prod_q16;

  skf_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == skf_pkg::REG_MEASURE_NOISE) ? mn_r : pn_r;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign psum     = {1'b0, var_r} + {1'b0, pn_r};
  assign p_pred   = psum[skf_pkg::DATA_W] ? '1 : psum[skf_pkg::DATA_W-1:0];
  assign rem_sh   = {rem_r[skf_pkg::DATA_W:0], 1'b0};
  assign rem_sub  = {1'b0, rem_sh} - {2'b00, s_r};
  assign diff     = {z_r[skf_pkg::DATA_W-1], z_r} - {ev_r[skf_pkg::DATA_W-1], ev_r};
  assign prod_q16 = prod_r[skf_pkg::DATA_W+15:16];

  // multiplier operands: gain*diff for the estimate, p*(1-gain) for the variance
  always_comb begin
    if (state_r == S_MUL_VAR) begin
      mul_a = {2'b00, p_r};
      mul_b = {1'b0, skf_pkg::ONE_Q16 - {1'b0, q_r}};
    end else begin
      mul_a = {diff[skf_pkg::DATA_W], diff};
      mul_b = {2'b00, q_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pn_nxt        = pn_r;
    mn_nxt        = mn_r;
    z_nxt         = z_r;
    ev_nxt        = ev_r;
    var_nxt       = var_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      if (paddr[2] == skf_pkg::REG_MEASURE_NOISE) begin
        mn_nxt = pwdata;
      end else begin
        pn_nxt = pwdata;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          z_nxt = in_data.measurement;
          if (in_data.restart) begin
            ev_nxt  = '0;
            var_nxt = '0;
          end
          state_nxt = S_PRED;
        end
      end
      S_PRED: begin
        p_nxt   = p_pred;
        s_nxt   = {1'b0, p_pred} + {1'b0, mn_r};
        rem_nxt = {2'b00, p_pred};
        cnt_nxt = '0;
        q_nxt   = '0;
        if (mn_r == '0) begin
          // p equals s: gain saturates, or is zero when s is zero
          q_nxt     = (p_pred == '0) ? '0 : skf_pkg::GAIN_MAX;
          state_nxt = S_MUL_EST;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!rem_sub[skf_pkg::DATA_W+2]) begin
          rem_nxt = rem_sub[skf_pkg::DATA_W+1:0];
        end else begin
          rem_nxt = rem_sh;
        end
        q_nxt   = {q_r[skf_pkg::GAIN_W-2:0], ~rem_sub[skf_pkg::DATA_W+2]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_MUL_EST;
        end
      end
      S_MUL_EST: begin
        state_nxt = S_MUL_VAR;
      end
      S_MUL_VAR: begin
        ev_nxt    = ev_r + $signed(prod_q16);
        state_nxt = S_VAR;
      end
      S_VAR: begin
        var_nxt   = prod_q16;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.estimate = ev_r;
          out_nxt.gain     = q_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pn_r        <= skf_pkg::PROCESS_NOISE_RST;
      mn_r        <= skf_pkg::MEASURE_NOISE_RST;
      ev_r        <= '0;
      var_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pn_r        <= pn_nxt;
      mn_r        <= mn_nxt;
      ev_r        <= ev_nxt;
      var_r       <= var_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r   <= z_nxt;
    p_r   <= p_nxt;
    s_r   <= s_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

### sv/skf_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module skf_mul (
  input  wire logic                                  clk,
  input  wire logic signed [skf_pkg::MUL_A_W-1:0]    mul_a,
  input  wire logic signed [skf_pkg::MUL_B_W-1:0]    mul_b,
  output logic signed      [skf_pkg::MUL_P_W-1:0]    prod_r
);

  logic signed [skf_pkg::MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

### sv/skf_checker.sv
// Checker: port-level assertions for the scalar Kalman filter, with bind.
`timescale 1ns / 1ps
`default_nettype none
module skf_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire skf_pkg::out_t out_data,
  input wire logic          pready
);

  // filter is busy, with in_ready low, right after each input transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("in_ready came back too early after an input transaction");

  // no result appears right after an input transaction taken while no result was pending
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("result appeared too soon after input transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed or dropped");

  assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready deasserted");

endmodule

bind scalar_kalman_filter_top skf_checker u_skf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
`default_nettype wire
